// ----- rtl/sensor_heartbeat_watchdog_unit_macros.svh -----
// assertion helpers shared by the watchdog checks
`ifndef SENSOR_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH
`define SENSOR_HEARTBEAT_WATCHDOG_UNIT_MACROS_SVH

// checked only out of reset
`define SHBWD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// checked at every edge, reset included
`define SHBWD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// ----- rtl/shbwd_pkg.sv -----
package shbwd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_SOURCES     = 5;

    localparam int CMD_W  = 2;
    localparam int SRC_W  = 3;
    localparam int TMO_W  = 16;
    localparam int LCNT_W = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATE     = 2'd2;

    // heartbeat sources
    localparam int SRC_SINGLE = 0;
    localparam int SRC_FRONT  = 1;
    localparam int SRC_BACK   = 2;
    localparam int SRC_ODOM   = 3;
    localparam int SRC_ENC    = 4;

    // laser count codes
    localparam logic [LCNT_W-1:0] LCNT_SINGLE = 2'd1;
    localparam logic [LCNT_W-1:0] LCNT_PAIR   = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_EN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LASER_EN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ODOM_EN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ENC_EN      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LASER_COUNT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LASER_TMO   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ODOM_TMO    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ENC_TMO     = 3'd7;

    // register reset values
    localparam logic              RST_GLOBAL_EN   = 1'b0;
    localparam logic              RST_CHECK_EN    = 1'b1;
    localparam logic [LCNT_W-1:0] RST_LASER_COUNT = 2'd2;
    localparam logic [TMO_W-1:0]  RST_LASER_TMO   = 16'd10;
    localparam logic [TMO_W-1:0]  RST_ODOM_TMO    = 16'd7;
    localparam logic [TMO_W-1:0]  RST_ENC_TMO     = 16'd7;

    typedef struct packed {
        logic any_error;
        logic laser_error;
        logic odometry_error;
        logic encoder_error;
    } status_word_t;

endpackage

// ----- rtl/sensor_heartbeat_watchdog_unit.sv -----
// a tick's result is registered in the output slot, or in the skid entry when that is held
// one word per cycle while s_ready is high; heartbeat/state words update state, emit nothing
// an output register plus one skid entry let input run while a result waits
// reset (aresetn low, synchronous): counters and statuses clear, controller reads not normal,
// registers take their default values and both result slots empty
module sensor_heartbeat_watchdog_unit #(
    parameter int COUNT_WIDTH = shbwd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [shbwd_pkg::CMD_W-1:0]       s_command,
    input  logic [shbwd_pkg::SRC_W-1:0]       s_source,
    input  logic                              s_mcu_is_normal,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_any_error,
    output logic                              m_laser_error,
    output logic                              m_odometry_error,
    output logic                              m_encoder_error,

    input  logic                              cfg_wr_en,
    input  logic [shbwd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [shbwd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CMP_W = (COUNT_WIDTH > shbwd_pkg::TMO_W) ? COUNT_WIDTH : shbwd_pkg::TMO_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic                              global_en_reg;
    logic                              laser_en_reg;
    logic                              odom_en_reg;
    logic                              enc_en_reg;
    logic [shbwd_pkg::LCNT_W-1:0]      laser_count_reg;
    logic [shbwd_pkg::TMO_W-1:0]       laser_tmo_reg;
    logic [shbwd_pkg::TMO_W-1:0]       odom_tmo_reg;
    logic [shbwd_pkg::TMO_W-1:0]       enc_tmo_reg;

    // watchdog state
    logic [COUNT_WIDTH-1:0]            elapsed_reg [shbwd_pkg::NUM_SOURCES];
    logic [COUNT_WIDTH-1:0]            elapsed_inc [shbwd_pkg::NUM_SOURCES];
    logic                              laser_st_reg;
    logic                              odom_st_reg;
    logic                              enc_st_reg;
    logic                              laser_st_next;
    logic                              odom_st_next;
    logic                              enc_st_next;
    logic                              ctrl_normal_reg;

    // result slots
    logic                              out_valid_reg;
    shbwd_pkg::status_word_t           out_word_reg;
    logic                              skid_valid_reg;
    shbwd_pkg::status_word_t           skid_word_reg;
    shbwd_pkg::status_word_t           new_word;

    logic                              accept;
    logic                              is_tick;
    logic                              push;
    logic                              pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign is_tick = (s_command == shbwd_pkg::CMD_TICK);
    assign push    = accept && is_tick;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_en_reg   <= shbwd_pkg::RST_GLOBAL_EN;
            laser_en_reg    <= shbwd_pkg::RST_CHECK_EN;
            odom_en_reg     <= shbwd_pkg::RST_CHECK_EN;
            enc_en_reg      <= shbwd_pkg::RST_CHECK_EN;
            laser_count_reg <= shbwd_pkg::RST_LASER_COUNT;
            laser_tmo_reg   <= shbwd_pkg::RST_LASER_TMO;
            odom_tmo_reg    <= shbwd_pkg::RST_ODOM_TMO;
            enc_tmo_reg     <= shbwd_pkg::RST_ENC_TMO;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                shbwd_pkg::REG_GLOBAL_EN:   global_en_reg   <= cfg_wdata[0];
                shbwd_pkg::REG_LASER_EN:    laser_en_reg    <= cfg_wdata[0];
                shbwd_pkg::REG_ODOM_EN:     odom_en_reg     <= cfg_wdata[0];
                shbwd_pkg::REG_ENC_EN:      enc_en_reg      <= cfg_wdata[0];
                shbwd_pkg::REG_LASER_COUNT: laser_count_reg <= cfg_wdata[shbwd_pkg::LCNT_W-1:0];
                shbwd_pkg::REG_LASER_TMO:   laser_tmo_reg   <= cfg_wdata[shbwd_pkg::TMO_W-1:0];
                shbwd_pkg::REG_ODOM_TMO:    odom_tmo_reg    <= cfg_wdata[shbwd_pkg::TMO_W-1:0];
                shbwd_pkg::REG_ENC_TMO:     enc_tmo_reg     <= cfg_wdata[shbwd_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating increment of every counter
    always_comb begin
        for (int i = 0; i < shbwd_pkg::NUM_SOURCES; i++) begin
            elapsed_inc[i] = (elapsed_reg[i] == CNT_MAX) ? elapsed_reg[i]
                                                         : elapsed_reg[i] + 1'b1;
        end
    end

    function automatic logic late(input logic [COUNT_WIDTH-1:0] cnt,
                                  input logic [shbwd_pkg::TMO_W-1:0] limit);
        return CMP_W'(cnt) > CMP_W'(limit);
    endfunction

    // status judged against the counters after this tick's increment; all clear while global enable is off
    always_comb begin
        laser_st_next = laser_st_reg;
        odom_st_next  = odom_st_reg;
        enc_st_next   = enc_st_reg;
        if (!global_en_reg) begin
            laser_st_next = 1'b0;
            odom_st_next  = 1'b0;
            enc_st_next   = 1'b0;
        end else begin
            if (laser_en_reg) begin
                case (laser_count_reg)
                    shbwd_pkg::LCNT_SINGLE:
                        laser_st_next = late(elapsed_inc[shbwd_pkg::SRC_SINGLE], laser_tmo_reg);
                    shbwd_pkg::LCNT_PAIR:
                        laser_st_next = late(elapsed_inc[shbwd_pkg::SRC_FRONT], laser_tmo_reg)
                                     || late(elapsed_inc[shbwd_pkg::SRC_BACK], laser_tmo_reg);
                    default: ;
                endcase
            end
            if (odom_en_reg) begin
                odom_st_next = ctrl_normal_reg
                            && late(elapsed_inc[shbwd_pkg::SRC_ODOM], odom_tmo_reg);
            end
            if (enc_en_reg) begin
                enc_st_next = late(elapsed_inc[shbwd_pkg::SRC_ENC], enc_tmo_reg);
            end
        end
        new_word.any_error      = laser_st_next || odom_st_next || enc_st_next;
        new_word.laser_error    = laser_st_next;
        new_word.odometry_error = odom_st_next;
        new_word.encoder_error  = enc_st_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < shbwd_pkg::NUM_SOURCES; i++) begin
                elapsed_reg[i] <= '0;
            end
            laser_st_reg    <= 1'b0;
            odom_st_reg     <= 1'b0;
            enc_st_reg      <= 1'b0;
            ctrl_normal_reg <= 1'b0;
        end else if (accept) begin
            case (s_command)
                shbwd_pkg::CMD_TICK: begin
                    for (int i = 0; i < shbwd_pkg::NUM_SOURCES; i++) begin
                        elapsed_reg[i] <= elapsed_inc[i];
                    end
                    laser_st_reg <= laser_st_next;
                    odom_st_reg  <= odom_st_next;
                    enc_st_reg   <= enc_st_next;
                end
                shbwd_pkg::CMD_HEARTBEAT: begin
                    // sources past the encoder are ignored
                    for (int i = 0; i < shbwd_pkg::NUM_SOURCES; i++) begin
                        if (s_source == shbwd_pkg::SRC_W'(i)) begin
                            elapsed_reg[i] <= '0;
                        end
                    end
                end
                shbwd_pkg::CMD_STATE: begin
                    ctrl_normal_reg <= s_mcu_is_normal;
                end
                default: ;
            endcase
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_word_reg <= skid_word_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_word_reg <= new_word;
            end else begin
                skid_word_reg <= new_word;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_any_error      = out_word_reg.any_error;
    assign m_laser_error    = out_word_reg.laser_error;
    assign m_odometry_error = out_word_reg.odometry_error;
    assign m_encoder_error  = out_word_reg.encoder_error;

endmodule

// ----- rtl/shbwd_checker.sv -----
`include "sensor_heartbeat_watchdog_unit_macros.svh"

module shbwd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [shbwd_pkg::CMD_W-1:0]       s_command,
    input logic [shbwd_pkg::SRC_W-1:0]       s_source,
    input logic                              s_mcu_is_normal,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_any_error,
    input logic                              m_laser_error,
    input logic                              m_odometry_error,
    input logic                              m_encoder_error,
    input logic                              cfg_wr_en,
    input logic [shbwd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input logic [shbwd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic       tick_in;
    logic       unused_inputs;
    logic       chan_error;
    logic [3:0] out_bits;

    assign tick_in = s_valid && s_ready && (s_command == shbwd_pkg::CMD_TICK);
    assign unused_inputs = ^{s_source, s_mcu_is_normal, cfg_wr_en, cfg_addr, cfg_wdata};
    assign chan_error = m_laser_error || m_odometry_error || m_encoder_error
                     || (unused_inputs && 1'b0);
    assign out_bits = {m_any_error, m_laser_error, m_odometry_error, m_encoder_error};

    // a reset leaves no result behind
    `SHBWD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // after an accepted tick, m_valid is high on the next edge
    `SHBWD_ASSERT(a_tick_result, aclk, aresetn, tick_in |=> m_valid)

    // with nothing waiting, heartbeat and state words emit nothing
    `SHBWD_ASSERT(a_no_spurious, aclk, aresetn, (!m_valid && !tick_in) |=> !m_valid)

    // summary bit matches the channel bits
    `SHBWD_ASSERT(a_any_error, aclk, aresetn, m_valid |-> (m_any_error == chan_error))

    // stalled result holds
    `SHBWD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(out_bits))

endmodule

bind sensor_heartbeat_watchdog_unit shbwd_checker u_shbwd_checker (.*);
